@@ design/tbpc_pkg.sv @@
// Shared types and constants for the two-button panel controller.
`timescale 1ns / 1ps
package tbpc_pkg;

	localparam logic [9:0] HOLD_TICKS  = 10'd300;
	localparam logic [9:0] LEVEL_TICKS = 10'd200;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_SETUP = 2'd2;

	localparam logic [1:0] LAMP_OFF    = 2'd0;
	localparam logic [1:0] LAMP_BLINK  = 2'd1;
	localparam logic [1:0] LAMP_STEADY = 2'd2;

	localparam logic [1:0] VIEW_AUTO  = 2'd0;
	localparam logic [1:0] VIEW_LEVEL = 2'd1;
	localparam logic [1:0] VIEW_ERROR = 2'd2;

	localparam logic [6:0] LEVEL_FULL = 7'd100;
	localparam logic [3:0] AUTO_MAX   = 4'd9;

	typedef struct packed {
		logic [1:0] lock;
		logic [1:0] err;
		logic [1:0] cart;
		logic [1:0] cat;
		logic [3:0] slot;
	} lamps_t;

	typedef struct packed {
		logic [1:0] view;
		logic       start_program;
		logic       beep;
		lamps_t     lamps;
	} result_t;

endpackage

@@ design/two_button_panel_controller.sv @@
// Top level of the two-button panel controller.
//
// Channel   | Direction | Payload
// s_axis    | in        | tdata: released, program_running; tuser: operation
// m_axis    | out       | tdata: slot_lamps .. view (16 bits)
// cfg       | in        | error_code write, no read-back
//
// Input register, then output register; one transaction per cycle unless the output stalls.
// The input register holds the item; state and result update as it moves to the output register.
// A stalled output register stalls the input register; each stage holds while blocked.
// Reset clears panel state, lamps and both stage valids.
`timescale 1ns / 1ps
module two_button_panel_controller
	import tbpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // released, program_running, zero fill
	input  logic [1:0]  s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // slot_lamps, cat_lamp, cartridge_lamp,
	                                   // error_lamp, lock_lamp, beep, start_program, view
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata
);

	function automatic lamps_t refresh(input logic [1:0] view, input logic [6:0] level,
		input logic [3:0] auto_set, input logic [2:0] err_code, input lamps_t cur);
		lamps_t l;
		l = cur;
		if (view == VIEW_LEVEL) begin
			l.err  = LAMP_OFF;
			l.cart = LAMP_STEADY;
			l.slot = {level >= 7'd75, level >= 7'd50, level >= 7'd25, level >= 7'd10};
			l.cat  = (level >= LEVEL_FULL) ? LAMP_STEADY : LAMP_OFF;
		end else if (view == VIEW_ERROR) begin
			l.err  = LAMP_BLINK;
			l.cart = LAMP_OFF;
			case (err_code)
				3'd1:    l.slot = 4'b0001;
				3'd2:    l.slot = 4'b0010;
				3'd3:    l.slot = 4'b0100;
				3'd4:    l.slot = 4'b1000;
				default: l.slot = 4'b0000;
			endcase
		end else begin
			l.err  = LAMP_OFF;
			l.cart = (level >= 7'd10) ? LAMP_OFF : LAMP_BLINK;
			l.cat  = LAMP_STEADY;
			case (auto_set)
				4'd1:    begin l.slot = 4'b0001; l.cat = LAMP_OFF; end
				4'd2:    begin l.slot = 4'b0010; l.cat = LAMP_OFF; end
				4'd3:    begin l.slot = 4'b0100; l.cat = LAMP_OFF; end
				4'd4:    begin l.slot = 4'b1000; l.cat = LAMP_OFF; end
				4'd5:    l.slot = 4'b0001;
				4'd6:    l.slot = 4'b0011;
				4'd7:    l.slot = 4'b0101;
				4'd8:    l.slot = 4'b1001;
				4'd9:    l.slot = 4'b0000;
				default: begin l.slot = 4'b0000; l.cat = LAMP_OFF; end
			endcase
		end
		return l;
	endfunction

	function automatic logic [6:0] next_level(input logic [6:0] level);
		logic [6:0] n;
		if (level < 7'd10)            n = 7'd10;
		else if (level < 7'd25)       n = 7'd25;
		else if (level < 7'd50)       n = 7'd50;
		else if (level < 7'd75)       n = 7'd75;
		else if (level < LEVEL_FULL)  n = LEVEL_FULL;
		else                          n = 7'd0;
		return n;
	endfunction

	logic       valid_s1;
	logic [1:0] op_s1;
	logic       released_s1;
	logic       running_s1;
	logic       advance;

	logic [2:0] error_code_q;
	logic       start_down_q, setup_down_q, chord_seen_q, lock_flag_q, hold_armed_q;
	logic [1:0] view_q;
	logic [3:0] auto_q;
	logic [6:0] level_q;
	logic [9:0] hold_count_q, level_count_q;
	lamps_t     lamps_q;

	logic       start_down_d, setup_down_d, chord_seen_d, lock_flag_d, hold_armed_d;
	logic [1:0] view_d;
	logic [3:0] auto_d;
	logic [6:0] level_d;
	logic [9:0] hold_count_d, level_count_d;
	lamps_t     lamps_d;
	logic       beep_d, req_d;

	logic       out_valid_q;
	result_t    out_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1       <= s_axis_tuser;
			released_s1 <= s_axis_tdata[0];
			running_s1  <= s_axis_tdata[1];
		end
	end

	always_comb begin
		logic mine_start;
		logic other;
		logic do_refresh;
		mine_start    = (op_s1 == OP_START);
		other         = mine_start ? setup_down_q : start_down_q;
		do_refresh    = 1'b0;
		start_down_d  = start_down_q;
		setup_down_d  = setup_down_q;
		chord_seen_d  = chord_seen_q;
		lock_flag_d   = lock_flag_q;
		hold_armed_d  = hold_armed_q;
		view_d        = view_q;
		auto_d        = auto_q;
		level_d       = level_q;
		hold_count_d  = hold_count_q;
		level_count_d = level_count_q;
		lamps_d       = lamps_q;
		beep_d        = 1'b0;
		req_d         = 1'b0;
		case (op_s1)
			OP_TICK: begin
				if (hold_count_q != 10'd0) hold_count_d = hold_count_q - 10'd1;
				if (level_count_q != 10'd0) level_count_d = level_count_q - 10'd1;
				if (view_q == VIEW_LEVEL && level_count_d == 10'd0) begin
					view_d     = (error_code_q != 3'd0) ? VIEW_ERROR : VIEW_AUTO;
					do_refresh = 1'b1;
				end
			end
			OP_START, OP_SETUP: begin
				if (!released_s1) begin
					if (mine_start) start_down_d = 1'b1;
					else            setup_down_d = 1'b1;
					hold_count_d = HOLD_TICKS;
					hold_armed_d = 1'b1;
					if (other) chord_seen_d = 1'b1;
					if (!lock_flag_q) beep_d = 1'b1;
					else              lamps_d.lock = LAMP_BLINK;
				end else begin
					if (mine_start) start_down_d = 1'b0;
					else            setup_down_d = 1'b0;
					if (!chord_seen_q) begin
						if (lock_flag_q) begin
							lamps_d.lock = LAMP_STEADY;
						end else if (mine_start) begin
							req_d = !running_s1;
						end else if (view_q == VIEW_LEVEL) begin
							level_d       = next_level(level_q);
							level_count_d = LEVEL_TICKS;
							do_refresh    = 1'b1;
						end else if (view_q != VIEW_ERROR) begin
							view_d     = VIEW_AUTO;
							auto_d     = (auto_q >= AUTO_MAX) ? 4'd0 : auto_q + 4'd1;
							do_refresh = 1'b1;
						end
					end else if (!other) begin
						if (hold_armed_q && hold_count_q == 10'd0) begin
							lock_flag_d  = !lock_flag_q;
							lamps_d.lock = lock_flag_q ? LAMP_OFF : LAMP_STEADY;
						end else if (lock_flag_q) begin
							lamps_d.lock = LAMP_STEADY;
						end else begin
							view_d        = VIEW_LEVEL;
							level_count_d = LEVEL_TICKS;
							do_refresh    = 1'b1;
						end
						chord_seen_d = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		if (do_refresh) begin
			lamps_d = refresh(view_d, level_d, auto_d, error_code_q, lamps_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_code_q <= 3'd0;
		end else if (cfg_we) begin
			error_code_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_down_q  <= 1'b0;
			setup_down_q  <= 1'b0;
			chord_seen_q  <= 1'b0;
			lock_flag_q   <= 1'b0;
			hold_armed_q  <= 1'b0;
			view_q        <= VIEW_AUTO;
			auto_q        <= 4'd0;
			level_q       <= LEVEL_FULL;
			hold_count_q  <= 10'd0;
			level_count_q <= 10'd0;
			lamps_q       <= '0;
		end else if (advance) begin
			start_down_q  <= start_down_d;
			setup_down_q  <= setup_down_d;
			chord_seen_q  <= chord_seen_d;
			lock_flag_q   <= lock_flag_d;
			hold_armed_q  <= hold_armed_d;
			view_q        <= view_d;
			auto_q        <= auto_d;
			level_q       <= level_d;
			hold_count_q  <= hold_count_d;
			level_count_q <= level_count_d;
			lamps_q       <= lamps_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.view          <= view_d;
			out_q.start_program <= req_d;
			out_q.beep          <= beep_d;
			out_q.lamps         <= lamps_d;
		end
	end

endmodule

@@ design/tbpc_checker.sv @@
// Port-level checks for the two-button panel controller, bound to the top level.
`timescale 1ns / 1ps
module tbpc_checker
	import tbpc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	result_t res;
	assign res = m_axis_tdata;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_start_no_beep: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.start_program |-> !res.beep)
		else $error("start request and beep in one transaction");

	a_level_view: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.view == VIEW_LEVEL |->
		res.lamps.cart == LAMP_STEADY && res.lamps.err == LAMP_OFF)
		else $error("level view with wrong lamps");

	a_error_view: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.view == VIEW_ERROR |->
		res.lamps.err == LAMP_BLINK && res.lamps.cart == LAMP_OFF &&
		$countones(res.lamps.slot) <= 1)
		else $error("error view with wrong lamps");

endmodule

bind two_button_panel_controller tbpc_checker u_tbpc_checker (.*);
